// File: design/fpp_pkg.sv
// Shared types and constants for the farthest point pair block.
// No dependencies.
package fpp_pkg;
	localparam int MaxPoints  = 1024;
	localparam int IdxW       = 10;
	localparam int CntW       = 11;
	localparam int CoordW     = 24;
	localparam int SqW        = 52;
	localparam int DistW      = 26;
	localparam logic [DistW-1:0] DistMax = 26'h3FFFFFF;

	typedef struct packed {
		logic signed [CoordW-1:0] x_coord;
		logic signed [CoordW-1:0] y_coord;
		logic signed [CoordW-1:0] z_coord;
		logic                     last_point;
	} point_in_t;

	typedef struct packed {
		logic [DistW-1:0] max_distance;
		logic [IdxW-1:0]  first_index;
		logic [IdxW-1:0]  second_index;
		logic             overflow;
	} result_t;

	typedef struct packed {
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic signed [CoordW-1:0] z;
	} point_t;
endpackage

// File: design/farthest_point_pair.sv
// Top level of the farthest point pair block.
// Depends on fpp_pkg, fpp_ram, fpp_cell, fpp_sqrt.
//
// Points arrive on the command channel: a transfer happens when start is high
// and busy is low. Each point is written to a 1024-entry store, so points load
// back to back. A point with last_point set starts the scan of every pair i<=j
// in load order; busy stays high until the result is shown.
// Each row i first fetches point i, then issues one pair a cycle through a
// store read and a row of three axis cells that pass a partial sum to their
// neighbor. A drain phase and a bit-serial square root follow; done then
// rises, and busy drops in the next cycle.
// The result appears for one cycle with done high; the receiver cannot stall.
// Points beyond 1024 are dropped and flagged in overflow.
// Reset clears the count, the flags and sets num_dims to 3; the store is
// not cleared. num_dims is written through cfg_we/cfg_data; the user must
// write it only while idle, as the block itself does not enforce this.
module farthest_point_pair (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  fpp_pkg::point_in_t   point,
	output logic                 busy,
	output logic                 done,
	output fpp_pkg::result_t     result,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_data
);
	localparam logic [1:0] StIdle = 2'd0, StScan = 2'd1, StDrain = 2'd2, StRoot = 2'd3;
	logic [1:0] state_q;
	logic [1:0] dims_q;
	logic [fpp_pkg::CntW-1:0] count_q;
	logic ovf_q;
	logic [fpp_pkg::IdxW-1:0] i_q, j_q;
	logic [fpp_pkg::IdxW-1:0] cur_i_q;
	fpp_pkg::point_t pi_q;
	logic [fpp_pkg::CntW-1:0] last_idx;
	logic accept, wr;
	logic [2:0] drain_q;
	logic issue;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [fpp_pkg::IdxW-1:0] ia_s1, ja_s1, ia_s2, ja_s2, ia_s3, ja_s3, ia_s4, ja_s4;
	logic [fpp_pkg::IdxW-1:0] ia_s5, ja_s5;
	logic [71:0] rdata;
	fpp_pkg::point_t rp;
	logic [fpp_pkg::SqW-1:0] s0, s1, s2;
	logic [fpp_pkg::SqW-1:0] best_q;
	logic [fpp_pkg::IdxW-1:0] bi_q, bj_q;
	logic root_go, root_done;
	logic [fpp_pkg::DistW-1:0] root;
	logic [fpp_pkg::IdxW-1:0] raddr;
	logic sel_i;
	logic ld_i_s1, ld_i_s2;

	assign accept = start && !busy;
	assign busy   = (state_q != StIdle);
	assign wr     = accept && (count_q < fpp_pkg::CntW'(fpp_pkg::MaxPoints));
	assign last_idx = count_q - fpp_pkg::CntW'(1);

	fpp_ram #(.Width(72), .Depth(fpp_pkg::MaxPoints)) u_ram (
		.clk(clk), .we(wr), .waddr(count_q[fpp_pkg::IdxW-1:0]),
		.wdata({point.x_coord, point.y_coord, point.z_coord}),
		.raddr(raddr), .rdata(rdata));
	assign rp = rdata;

	// scan: at start of row i, read point i once (sel_i), then points j=i..N-1
	assign sel_i = (state_q == StScan) && (j_q == i_q) && !ld_i_s1 && !ld_i_s2
		&& !(cur_i_q == i_q && v_s1);
	assign issue = (state_q == StScan) && !sel_i;
	assign raddr = issue ? j_q : i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			dims_q  <= 2'd3;
			count_q <= '0;
			ovf_q   <= 1'b0;
			i_q <= '0; j_q <= '0;
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			ld_i_s1 <= 1'b0; ld_i_s2 <= 1'b0;
			drain_q <= '0;
			root_go <= 1'b0;
			best_q <= '0; bi_q <= '0; bj_q <= '0;
			cur_i_q <= '1;
		end else begin
			root_go <= 1'b0;
			if (cfg_we) dims_q <= cfg_data;
			ld_i_s1 <= sel_i;
			ld_i_s2 <= ld_i_s1;
			v_s1 <= issue; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
			unique case (state_q)
				StIdle: begin
					if (accept) begin
						if (wr) count_q <= count_q + fpp_pkg::CntW'(1);
						else ovf_q <= 1'b1;
						if (point.last_point) begin
							best_q <= '0; bi_q <= '0; bj_q <= '0;
							i_q <= '0; j_q <= '0; cur_i_q <= '1;
							if (wr || count_q != '0) state_q <= StScan;
							else begin state_q <= StDrain; drain_q <= '0; end
						end
					end
				end
				StScan: begin
					if (sel_i) cur_i_q <= i_q;
					if (issue && cur_i_q == i_q && !ld_i_s1 && !ld_i_s2) begin
						if (fpp_pkg::CntW'(j_q) == last_idx) begin
							if (fpp_pkg::CntW'(i_q) == last_idx) begin
								state_q <= StDrain; drain_q <= '0;
							end else begin
								i_q <= i_q + 1'b1; j_q <= i_q + 1'b1;
							end
						end else j_q <= j_q + 1'b1;
					end
				end
				StDrain: begin
					drain_q <= drain_q + 3'd1;
					if (drain_q == 3'd6) begin state_q <= StRoot; root_go <= 1'b1; end
				end
				StRoot: begin
					if (root_done) begin
						state_q <= StIdle; count_q <= '0; ovf_q <= 1'b0;
					end
				end
				default: state_q <= StIdle;
			endcase
			if (v_s5 && s2 > best_q) begin
				best_q <= s2; bi_q <= ia_s5; bj_q <= ja_s5;
			end
		end
	end

	// issue pipeline: s1 ram read, s2 register, s3..s5 cells
	fpp_pkg::point_t a_s2, b_s2;
	fpp_pkg::point_t a_s3, b_s3, a_s4, b_s4;
	always_ff @(posedge clk) begin
		ia_s1 <= i_q; ja_s1 <= j_q;
		ia_s2 <= ia_s1; ja_s2 <= ja_s1;
		ia_s3 <= ia_s2; ja_s3 <= ja_s2;
		ia_s4 <= ia_s3; ja_s4 <= ja_s3;
		ia_s5 <= ia_s4; ja_s5 <= ja_s4;
		if (ld_i_s1) pi_q <= rp;
		a_s2 <= ld_i_s1 ? rp : pi_q;
		b_s2 <= rp;
	end
	// each cell sees its neighbor's sum in the following cycle, so delay its coordinates
	always_ff @(posedge clk) begin
		a_s3 <= a_s2; b_s3 <= b_s2;
		a_s4 <= a_s3; b_s4 <= b_s3;
	end
	assign s0 = '0;
	logic [fpp_pkg::SqW-1:0] c0, c1;
	fpp_cell u_cx (.clk(clk), .en(dims_q >= 2'd1), .a(a_s2.x), .b(b_s2.x),
		.sum_in(s0), .sum_q(c0));
	fpp_cell u_cy (.clk(clk), .en(dims_q >= 2'd2), .a(a_s3.y), .b(b_s3.y),
		.sum_in(c0), .sum_q(c1));
	assign s1 = c1;
	logic [fpp_pkg::SqW-1:0] c2;
	fpp_cell u_cz (.clk(clk), .en(dims_q == 2'd3), .a(a_s4.z), .b(b_s4.z),
		.sum_in(s1), .sum_q(c2));
	assign s2 = c2;

	fpp_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .go(root_go), .val(best_q),
		.done(root_done), .root(root));

	always_comb begin
		result.max_distance = root;
		result.first_index  = bi_q;
		result.second_index = bj_q;
		result.overflow     = ovf_q;
	end
	assign done = root_done;
endmodule

// File: design/fpp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module fpp_ram #(
	parameter int Width = 72,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: design/fpp_cell.sv
// One distance cell: squared difference of one axis, added to the neighbor's sum if en.
// Depends on fpp_pkg.
module fpp_cell (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [fpp_pkg::CoordW-1:0] a,
	input  logic signed [fpp_pkg::CoordW-1:0] b,
	input  logic [fpp_pkg::SqW-1:0]       sum_in,
	output logic [fpp_pkg::SqW-1:0]       sum_q
);
	logic signed [fpp_pkg::CoordW:0] d;
	logic [fpp_pkg::CoordW:0]        m;
	logic [2*fpp_pkg::CoordW+1:0]    sq;
	always_comb begin
		d  = {a[fpp_pkg::CoordW-1], a} - {b[fpp_pkg::CoordW-1], b};
		m  = d[fpp_pkg::CoordW] ? -d : d;
		sq = m * m;
	end
	always_ff @(posedge clk) begin
		sum_q <= en ? sum_in + fpp_pkg::SqW'(sq) : sum_in;
	end
endmodule

// File: design/fpp_sqrt.sv
// Bit-serial floor square root, two radicand bits per cycle.
// Depends on fpp_pkg.
module fpp_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [fpp_pkg::SqW-1:0]    val,
	output logic                       done,
	output logic [fpp_pkg::DistW-1:0]  root
);
	logic [fpp_pkg::DistW-1:0] root_q;
	logic [4:0]                step_q;
	logic                      busy_q;
	logic [fpp_pkg::DistW+1:0] trial;
	always_comb trial = {root_q, 2'b01};
	// restoring algorithm on a remainder and a shifting radicand
	logic [fpp_pkg::SqW-1:0]   rad_q;
	logic [fpp_pkg::DistW+1:0] r_q;
	logic [fpp_pkg::DistW+1:0] r_next;
	always_comb r_next = {r_q[fpp_pkg::DistW-1:0], rad_q[fpp_pkg::SqW-1 -: 2]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == 5'd25) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (go) begin
			rad_q  <= val;
			r_q    <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[fpp_pkg::SqW-3:0], 2'b00};
			if (r_next >= trial) begin
				r_q    <= r_next - trial;
				root_q <= {root_q[fpp_pkg::DistW-2:0], 1'b1};
			end else begin
				r_q    <= r_next;
				root_q <= {root_q[fpp_pkg::DistW-2:0], 1'b0};
			end
		end
	end
	assign root = root_q;
endmodule

// File: tb/sv/tb_top.sv
// Testbench for farthest_point_pair: loads point sets, predicts the farthest pair
// and its floor distance, and checks each result transfer against that prediction.
// Depends on fpp_pkg and the farthest_point_pair RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CycleLimit = 3000000;
	localparam int SettleCycles = 60;

	logic clk, arst_n, start, busy, done, cfg_we;
	logic [1:0] cfg_data;
	fpp_pkg::point_in_t point;
	fpp_pkg::result_t result;

	farthest_point_pair dut (
		.clk(clk), .arst_n(arst_n), .start(start), .point(point), .busy(busy),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	fpp_pkg::point_in_t pending_points[$];
	fpp_pkg::result_t expected_results[$];
	fpp_pkg::point_t loaded_set[$];
	logic [1:0] dims_shadow;
	bit set_lost;
	bit took, hold;
	int idle_pct;
	int mismatches, results_seen, sets_sent, items_sent;
	int unsigned cycles;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned r, t;
		r = 0;
		for (int b = 25; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v) r = t;
		end
		return r;
	endfunction

	function automatic longint unsigned axis_sq(logic signed [fpp_pkg::CoordW-1:0] a,
			logic signed [fpp_pkg::CoordW-1:0] b);
		longint d;
		d = longint'(a) - longint'(b);
		if (d < 0) d = -d;
		return longint'(d) * longint'(d);
	endfunction

	function automatic fpp_pkg::result_t farthest_of_set();
		fpp_pkg::result_t r;
		longint unsigned best, d2;
		best = 0;
		r = '0;
		for (int i = 0; i < loaded_set.size(); i++)
			for (int j = i; j < loaded_set.size(); j++) begin
				d2 = 0;
				if (dims_shadow >= 1) d2 += axis_sq(loaded_set[i].x, loaded_set[j].x);
				if (dims_shadow >= 2) d2 += axis_sq(loaded_set[i].y, loaded_set[j].y);
				if (dims_shadow >= 3) d2 += axis_sq(loaded_set[i].z, loaded_set[j].z);
				if (d2 > best) begin
					best = d2;
					r.first_index = i[fpp_pkg::IdxW-1:0];
					r.second_index = j[fpp_pkg::IdxW-1:0];
				end
			end
		r.max_distance = fpp_pkg::DistW'(floor_root(best));
		r.overflow = set_lost;
		return r;
	endfunction

	// prediction on accepted point transfers, checking on result strobes
	always @(posedge clk) begin
		fpp_pkg::result_t exp_r;
		fpp_pkg::point_t p;
		cycles++;
		if (cycles > CycleLimit) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
		took = arst_n && start && !busy;
		if (took) begin
			p = '{point.x_coord, point.y_coord, point.z_coord};
			if (loaded_set.size() < fpp_pkg::MaxPoints) loaded_set = {loaded_set, p};
			else set_lost = 1;
			if (point.last_point) begin
				expected_results = {expected_results, farthest_of_set()};
				loaded_set.delete();
				set_lost = 0;
			end
		end
		if (arst_n && done) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result %p", result);
			end else begin
				exp_r = expected_results.pop_front();
				if (result.max_distance !== exp_r.max_distance ||
						result.first_index !== exp_r.first_index ||
						result.second_index !== exp_r.second_index ||
						result.overflow !== exp_r.overflow) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result mismatch: expected %p actual %p", exp_r, result);
				end
			end
		end
	end

	// driver: point transfers at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 0;
			point <= '0;
		end else if (!start || took) begin
			if (pending_points.size() != 0 && !hold && $urandom_range(99) >= idle_pct) begin
				point <= pending_points.pop_front();
				start <= 1;
				items_sent++;
			end else begin
				start <= 0;
			end
		end
	end

	function automatic logic signed [fpp_pkg::CoordW-1:0] pick_coord(int mode);
		case (mode)
			0: return fpp_pkg::CoordW'($urandom);
			1: return fpp_pkg::CoordW'(int'($urandom_range(8190)) - 4095);
			2: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
			default: return fpp_pkg::CoordW'($urandom_range(3));
		endcase
	endfunction

	task automatic queue_set(int n, int mode);
		fpp_pkg::point_in_t p;
		for (int k = 0; k < n; k++) begin
			p.x_coord = pick_coord(mode < 0 ? $urandom_range(3) : mode);
			p.y_coord = pick_coord(mode < 0 ? $urandom_range(3) : mode);
			p.z_coord = pick_coord(mode < 0 ? $urandom_range(3) : mode);
			p.last_point = (k == n - 1);
			pending_points = {pending_points, p};
		end
		sets_sent++;
	endtask

	task automatic queue_point(int x, int y, int z, bit last);
		fpp_pkg::point_in_t p;
		p = '{fpp_pkg::CoordW'(x), fpp_pkg::CoordW'(y), fpp_pkg::CoordW'(z), last};
		pending_points = {pending_points, p};
		if (last) sets_sent++;
	endtask

	task automatic drain();
		hold = 0;
		wait (pending_points.size() == 0);
		@(posedge clk);
		while (start || expected_results.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_dims(logic [1:0] v);
		@(negedge clk);
		cfg_we <= 1;
		cfg_data <= v;
		dims_shadow = v;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_data = 0;
		dims_shadow = 3;
		idle_pct = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// single point, extremes, ties, all-equal set
		queue_point(123, -5, 7, 1);
		queue_point(-8388608, -8388608, -8388608, 0);
		queue_point(8388607, 8388607, 8388607, 1);
		queue_point(5, 5, 5, 0);
		queue_point(5, 5, 5, 0);
		queue_point(5, 5, 5, 1);
		queue_point(0, 0, 0, 0);
		queue_point(3, 0, 0, 0);
		queue_point(0, 3, 0, 0);
		queue_point(-3, 0, 0, 1);
		drain();
		for (int d = 0; d < 3; d++) begin
			write_dims(d[1:0]);
			queue_point(10, -8388608, 8388607, 0);
			queue_point(-10, 8388607, -8388608, 0);
			queue_point(10, 0, 0, 1);
			drain();
		end
		// store overflow, flagged point dropped too
		write_dims(3);
		queue_set(1026, 0);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			write_dims(ph == 3 ? 2'd1 : 2'(3 - ph));
			idle_pct = (ph == 1) ? 63 : (ph == 3) ? 17 : 0;
			for (int s = 0; s < 16; s++) queue_set($urandom_range(8, 1), -1);
			if (ph == 2) hold = 1;
			drain();
		end

		$display("Sent %0d points in %0d sets across four axis settings, store overflow included",
			items_sent, sets_sent);
		$display("Checked %0d results", results_seen);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
